[src/lz_flagword_decompressor_assert.svh]
// Assertion macros shared by the decompressor RTL.
`ifndef LZ_FLAGWORD_DECOMPRESSOR_ASSERT_SVH
`define LZ_FLAGWORD_DECOMPRESSOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define LZFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define LZFD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LZFD_ASSERT(lbl, prop, msg)
`define LZFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/lzfd_pkg.sv]
// Shared types, constants and token decode for the flag-word LZ decompressor.
`default_nettype none
package lzfd_pkg;

    localparam int LEN_W            = 31;
    localparam int WINDOW_BYTES     = 16384;
    localparam int HIST_AW          = $clog2(WINDOW_BYTES);
    localparam int TOKEN_SHIFT_BASE = 14;
    localparam int ITEMS_PER_FLAG   = 30;
    localparam int MIN_MATCH        = 3;
    localparam int BACK_W           = 15;
    localparam int MLEN_W           = 6;

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_DIST    = 2'd1,
        ERR_OVERRUN = 2'd2,
        ERR_EARLY   = 2'd3
    } err_t;

    typedef struct packed {
        len_t diff;
        logic lt;
    } alu_res_t;

    typedef struct packed {
        logic [BACK_W-1:0] back;
        logic [MLEN_W-1:0] mlen;
    } tok_t;

    // Split a 16-bit match token by the group's shift selector.
    function automatic tok_t token_split(input logic [15:0] t, input logic [1:0] shift_n);
        logic [13:0] mask;
        logic [15:0] sh;
        tok_t        r;
        mask   = 14'h3FFF >> shift_n;
        sh     = t >> (5'(TOKEN_SHIFT_BASE) - 5'(shift_n));
        r.back = BACK_W'(t[13:0] & mask) + BACK_W'(1);
        r.mlen = MLEN_W'(sh) + MLEN_W'(MIN_MATCH);
        return r;
    endfunction

endpackage
`default_nettype wire

[src/lzfd_alu.sv]
// Shared subtract/compare unit used by the decoder sequencer.
`default_nettype none
module lzfd_alu (
    input  wire lzfd_pkg::len_t   op_a,
    input  wire lzfd_pkg::len_t   op_b,
    output lzfd_pkg::alu_res_t    res
);
    import lzfd_pkg::*;

    logic [LEN_W:0] full;

    assign full     = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff = full[LEN_W-1:0];
    assign res.lt   = full[LEN_W];   // borrow: op_a < op_b

endmodule
`default_nettype wire

[src/lz_flagword_decompressor.sv]
// Top level: flag-word LZ decompressor with history memory and decode sequencer.
//
// Takes one compressed byte per input item and returns decompressed bytes
// (plus end and error markers) as output items. The block handles one input
// item at a time: tready is high only while the sequencer is idle. A flag-word
// byte or token high byte is only length-checked; a literal adds an emit step; a
// match adds distance and overrun checks, then copies len bytes (len 3..34), each
// a registered read of the single-port-read history memory followed by a write
// and an output push. The input-ended-early marker is its own step; an error item
// or length-reached marker is pushed in the cycle of the check that finds it. All
// range checks (length reached, bad distance, length overrun) go one after
// another through one shared 31-bit subtract/compare unit. The history (16 KiB)
// is not cleared; the distance check keeps reads inside written data, so there is
// no clearing pass after reset. Output items sit in a one-deep output register;
// the sequencer waits there only while that register is full and not taken.
// output_length may be written only while no item is in progress.
`default_nettype none
`include "lz_flagword_decompressor_assert.svh"
module lz_flagword_decompressor (
    input  wire        clk,
    input  wire        rst_n,
    // configuration
    input  wire        cfg_wr_en,
    input  wire [30:0] cfg_wr_data,       // output_length
    // compressed input
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,      // [7:0] in_byte
    input  wire        s_axis_tlast,      // in_last
    // decompressed output
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata,      // [7:0] out_byte
    output logic       m_axis_tlast,      // run_last
    output logic [2:0] m_axis_tuser       // [0] stream_end, [2:1] error_code
);
    import lzfd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,   // waiting for an input item
        S_LENCHK = 8'b0000_0010,   // output length reached? then parse byte
        S_LIT    = 8'b0000_0100,   // emit literal
        S_DIST   = 8'b0000_1000,   // distance check, source pointer
        S_OVR    = 8'b0001_0000,   // length overrun check
        S_RD     = 8'b0010_0000,   // history read
        S_WR     = 8'b0100_0000,   // history write and emit copied byte
        S_EARLY  = 8'b1000_0000    // input ended early marker
    } state_t;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_ITEM = 2'd1,
        PH_LOW  = 2'd2
    } phase_t;

    // control state
    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [31:0]         flag_word_reg, flag_word_next;
    logic [4:0]          items_left_reg, items_left_next;
    logic [1:0]          flag_cnt_reg, flag_cnt_next;
    len_t                bytes_out_reg, bytes_out_next;
    logic                finished_reg, finished_next;
    len_t                out_len_reg;
    logic [MLEN_W-1:0]   cnt_reg, cnt_next;
    logic                end_flag_reg, end_flag_next;
    logic                out_valid_reg;

    // payload
    logic [7:0]          in_byte_reg;
    logic                in_last_reg;
    logic [7:0]          token_high_reg, token_high_next;
    logic [BACK_W-1:0]   back_reg, back_next;
    logic [MLEN_W-1:0]   mlen_reg, mlen_next;
    len_t                rem_reg, rem_next;
    logic [HIST_AW-1:0]  src_reg, src_next;
    logic [7:0]          rd_data_reg;
    logic [7:0]          out_byte_reg;
    logic                out_last_reg;
    logic                out_end_reg;
    err_t                out_err_reg;

    logic [7:0]          hist [WINDOW_BYTES];

    // sequencer outputs
    logic                push;
    logic [7:0]          push_byte;
    logic                push_last;
    logic                push_end;
    err_t                push_err;
    logic                mem_we;
    logic [7:0]          mem_wdata;
    logic                mem_rd;

    logic                can_push;
    logic                in_accept;
    logic                flag_sel;
    logic [4:0]          items_dec;
    phase_t              phase_after;
    logic                copy_done;
    tok_t                tok;
    len_t                alu_a, alu_b;
    alu_res_t            alu_res;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign can_push      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_err_reg, out_end_reg};

    // current item: 1 bit of flag word marks a match token
    assign flag_sel = (items_left_reg != 5'd0) && (items_left_reg <= 5'(ITEMS_PER_FLAG))
                      && flag_word_reg[items_left_reg + 5'd1];

    // item finished: step down the group count
    assign items_dec   = (items_left_reg != 5'd0) ? items_left_reg - 5'd1 : items_left_reg;
    assign phase_after = (items_dec == 5'd0) ? PH_FLAG : PH_ITEM;

    assign tok       = token_split({token_high_reg, in_byte_reg}, flag_word_reg[1:0]);
    assign copy_done = (cnt_reg == MLEN_W'(1));

    // operand select for the shared compare unit
    always_comb
    begin
        case (state_reg)
            S_DIST:
            begin
                alu_a = bytes_out_reg;
                alu_b = LEN_W'(back_reg);
            end
            S_OVR:
            begin
                alu_a = rem_reg;
                alu_b = LEN_W'(mlen_reg);
            end
            default:
            begin
                alu_a = out_len_reg;
                alu_b = bytes_out_reg;
            end
        endcase
    end

    lzfd_alu u_alu (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        flag_word_next  = flag_word_reg;
        items_left_next = items_left_reg;
        flag_cnt_next   = flag_cnt_reg;
        bytes_out_next  = bytes_out_reg;
        finished_next   = finished_reg;
        cnt_next        = cnt_reg;
        end_flag_next   = end_flag_reg;
        token_high_next = token_high_reg;
        back_next       = back_reg;
        mlen_next       = mlen_reg;
        rem_next        = rem_reg;
        src_next        = src_reg;
        push            = 1'b0;
        push_byte       = 8'd0;
        push_last       = 1'b0;
        push_end        = 1'b0;
        push_err        = ERR_OK;
        mem_we          = 1'b0;
        mem_wdata       = in_byte_reg;
        mem_rd          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // items after the end are taken and dropped
                if (in_accept && !finished_reg)
                    state_next = S_LENCHK;
            end

            S_LENCHK:
            begin
                rem_next = alu_res.diff;   // output_length - bytes_out
                if (alu_res.lt || (alu_res.diff == '0))
                begin
                    // length already reached: end marker, byte not decoded
                    if (can_push)
                    begin
                        push          = 1'b1;
                        push_end      = 1'b1;
                        push_last     = 1'b1;
                        finished_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_ITEM:
                        begin
                            if (flag_sel)
                            begin
                                token_high_next = in_byte_reg;
                                phase_next      = PH_LOW;
                                state_next      = in_last_reg ? S_EARLY : S_IDLE;
                            end
                            else
                                state_next = S_LIT;
                        end
                        PH_LOW:
                        begin
                            back_next  = tok.back;
                            mlen_next  = tok.mlen;
                            state_next = S_DIST;
                        end
                        default:
                        begin
                            flag_word_next = {flag_word_reg[23:0], in_byte_reg};
                            if (flag_cnt_reg == 2'd3)
                            begin
                                flag_cnt_next   = 2'd0;
                                items_left_next = 5'(ITEMS_PER_FLAG);
                                phase_next      = PH_ITEM;
                            end
                            else
                            begin
                                flag_cnt_next = flag_cnt_reg + 2'd1;
                                phase_next    = PH_FLAG;
                            end
                            state_next = in_last_reg ? S_EARLY : S_IDLE;
                        end
                    endcase
                end
            end

            S_LIT:
            begin
                if (can_push)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = in_byte_reg;
                    push           = 1'b1;
                    push_byte      = in_byte_reg;
                    push_end       = (rem_reg == LEN_W'(1));
                    push_last      = (rem_reg == LEN_W'(1)) || !in_last_reg;
                    bytes_out_next = bytes_out_reg + LEN_W'(1);
                    if (rem_reg == LEN_W'(1))
                    begin
                        finished_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        items_left_next = items_dec;
                        phase_next      = phase_after;
                        state_next      = in_last_reg ? S_EARLY : S_IDLE;
                    end
                end
            end

            S_DIST:
            begin
                if (alu_res.lt)
                begin
                    // distance reaches before the first output byte
                    if (can_push)
                    begin
                        push          = 1'b1;
                        push_end      = 1'b1;
                        push_last     = 1'b1;
                        push_err      = ERR_DIST;
                        finished_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    src_next   = alu_res.diff[HIST_AW-1:0];
                    state_next = S_OVR;
                end
            end

            S_OVR:
            begin
                if (alu_res.lt)
                begin
                    // match runs past the expected length
                    if (can_push)
                    begin
                        push          = 1'b1;
                        push_end      = 1'b1;
                        push_last     = 1'b1;
                        push_err      = ERR_OVERRUN;
                        finished_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    end_flag_next = (alu_res.diff == '0);
                    cnt_next      = mlen_reg;
                    state_next    = S_RD;
                end
            end

            S_RD:
            begin
                mem_rd     = 1'b1;
                src_next   = src_reg + HIST_AW'(1);
                state_next = S_WR;
            end

            S_WR:
            begin
                if (can_push)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = rd_data_reg;
                    push           = 1'b1;
                    push_byte      = rd_data_reg;
                    push_end       = copy_done && end_flag_reg;
                    push_last      = copy_done && (end_flag_reg || !in_last_reg);
                    bytes_out_next = bytes_out_reg + LEN_W'(1);
                    cnt_next       = cnt_reg - MLEN_W'(1);
                    if (!copy_done)
                        state_next = S_RD;
                    else if (end_flag_reg)
                    begin
                        finished_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        items_left_next = items_dec;
                        phase_next      = phase_after;
                        state_next      = in_last_reg ? S_EARLY : S_IDLE;
                    end
                end
            end

            S_EARLY:
            begin
                if (can_push)
                begin
                    push          = 1'b1;
                    push_end      = 1'b1;
                    push_last     = 1'b1;
                    push_err      = ERR_EARLY;
                    finished_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FLAG;
            flag_word_reg  <= '0;
            items_left_reg <= '0;
            flag_cnt_reg   <= '0;
            bytes_out_reg  <= '0;
            finished_reg   <= 1'b0;
            out_len_reg    <= '0;
            cnt_reg        <= '0;
            end_flag_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_word_reg  <= flag_word_next;
            items_left_reg <= items_left_next;
            flag_cnt_reg   <= flag_cnt_next;
            bytes_out_reg  <= bytes_out_next;
            finished_reg   <= finished_next;
            cnt_reg        <= cnt_next;
            end_flag_reg   <= end_flag_next;
            if (cfg_wr_en)
                out_len_reg <= cfg_wr_data;
            if (push)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        token_high_reg <= token_high_next;
        back_reg       <= back_next;
        mlen_reg       <= mlen_next;
        rem_reg        <= rem_next;
        src_reg        <= src_next;
        if (push)
        begin
            out_byte_reg <= push_byte;
            out_last_reg <= push_last;
            out_end_reg  <= push_end;
            out_err_reg  <= push_err;
        end
    end

    // history memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist[bytes_out_reg[HIST_AW-1:0]] <= mem_wdata;
        if (mem_rd)
            rd_data_reg <= hist[src_reg];
    end

    `LZFD_ASSERT(a_finished_sticky, finished_reg |=> finished_reg, "finished cleared")
    `LZFD_ASSERT(a_end_sets_finished, (m_axis_tvalid && m_axis_tuser[0]) |-> (finished_reg && m_axis_tlast), "stream end without finish")
    `LZFD_ASSERT(a_error_item_shape, (m_axis_tvalid && (m_axis_tuser[2:1] != ERR_OK)) |-> (m_axis_tuser[0] && (m_axis_tdata == 8'd0)), "malformed error item")
    `LZFD_ASSERT(a_copy_count, ((state_reg == S_RD) || (state_reg == S_WR)) |-> (cnt_reg != '0), "copy with zero count")
    `LZFD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid, "output valid in reset")

endmodule
`default_nettype wire
